// ----- hw/rtl/cobs_dec_pkg.sv -----
// Shared types and constants for the COBS frame decoder.
package cobs_dec_pkg;

  localparam int unsigned LEN_BITS_DEF = 16;
  localparam int unsigned LEN_W        = 16;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned STAT_W       = 2;
  localparam int unsigned CFG_W        = 16;
  localparam int unsigned ADDR_W       = 3;
  localparam int unsigned IN_TDATA_W   = 8;
  localparam int unsigned OUT_TDATA_W  = 32;
  localparam int unsigned Q_DEPTH      = 4;

  localparam logic [BYTE_W-1:0] CODE_MAX = 8'hFF;
  localparam logic [CFG_W-1:0]  MAX_OUT_LEN_RST = 16'hFFFF;

  // Register word index in paddr[2]
  localparam logic REG_MAX_OUT_LEN = 1'b0;

  // Frame status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_NUL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_SHORT = 2'd2;
  localparam logic [STAT_W-1:0] ST_OVF   = 2'd3;

  typedef struct packed {
    logic [LEN_W-1:0]  decoded_length;
    logic [STAT_W-1:0] status;
    logic              frame_end;
    logic [BYTE_W-1:0] out_byte;
  } res_t;

  typedef struct packed {
    logic data_v;
    logic stat_v;
  } push_t;

endpackage

// ----- hw/rtl/cobs_dec_fifo.sv -----
// Result queue: takes up to two result items per cycle, gives one.
module cobs_dec_fifo
  import cobs_dec_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  input  res_t  data_res_i,
  input  res_t  stat_res_i,
  input  logic  pop_i,
  output res_t  head_o,
  output logic  not_empty_o,
  output logic  room2_o
);

  localparam int unsigned PTR_W = $clog2(Q_DEPTH);
  localparam int unsigned CNT_W = $clog2(Q_DEPTH + 1);

  res_t mem_q [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr2;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_pop;

  assign do_pop  = pop_i & (count_q != '0);
  // status item lands behind a data item of the same step
  assign wr_ptr2 = wr_ptr_q + PTR_W'(push_i.data_v);

  always_comb begin
    wr_ptr_d = wr_ptr_q + PTR_W'(push_i.data_v) + PTR_W'(push_i.stat_v);
    rd_ptr_d = rd_ptr_q + PTR_W'(do_pop);
    count_d  = count_q + CNT_W'(push_i.data_v) + CNT_W'(push_i.stat_v)
               - CNT_W'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.data_v) begin
      mem_q[wr_ptr_q] <= data_res_i;
    end
    if (push_i.stat_v) begin
      mem_q[wr_ptr2] <= stat_res_i;
    end
  end

  assign head_o      = mem_q[rd_ptr_q];
  assign not_empty_o = (count_q != '0);
  assign room2_o     = (count_q <= CNT_W'(Q_DEPTH - 2));

endmodule

// ----- hw/rtl/cobs_frame_decoder_unit.sv -----
// COBS frame decoder top level: decode step, capacity register, result queue.
//
//   channel   dir  handshake                tdata / tlast
//   s_axis    in   tvalid/tready            [7:0] byte_in; tlast = frame_last
//   m_axis    out  tvalid/tready            [7:0] out_byte, [9:8] status,
//                                           [25:10] decoded_length; tlast = frame_end
//   apb       in   psel/penable/pwrite      0x0 max_out_len [15:0]
//
// One encoded byte is accepted per cycle; its results enter a four-entry
// result queue in the same edge and show on m_axis from the queue head.
// A frame's last byte may give two results, a data item and a status
// item; the queue absorbs both and s_axis only stalls when fewer than two
// queue slots are free. rst_ni clears decoder state and the queue, and
// sets max_out_len to 0xFFFF. The state clears again after every frame end.
module cobs_frame_decoder_unit
  import cobs_dec_pkg::*;
#(
  parameter int unsigned LEN_BITS = LEN_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] byte_in
  input  logic                   s_axis_tlast,   // frame_last
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [7:0] out_byte, [9:8] status,
                                                 // [25:10] decoded_length
  output logic                   m_axis_tlast,   // frame_end
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [ADDR_W-1:0]      paddr,
  input  logic [31:0]            pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int unsigned CMP_W = (LEN_BITS > CFG_W) ? LEN_BITS : CFG_W;

  logic [CFG_W-1:0]    max_len_q;
  logic [BYTE_W-1:0]   rem_q, rem_d;
  logic                zp_q, zp_d;
  logic [LEN_BITS-1:0] cnt_q, cnt_d;
  logic [STAT_W-1:0]   err_q, err_d;

  logic                acc, ok, is_nul, code_slot, want, full, ovf, emit, adv;
  logic [BYTE_W-1:0]   b, rem_step;
  logic                zp_step;
  logic [LEN_BITS-1:0] cnt_step;
  logic [STAT_W-1:0]   err_step, err_fin;
  logic                room2;
  push_t               push;
  res_t                data_res, stat_res, head;

  // Configuration
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_MAX_OUT_LEN) ? {16'd0, max_len_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_OUT_LEN_RST;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_MAX_OUT_LEN) begin
      max_len_q <= pwdata[CFG_W-1:0];
    end
  end

  // Decode step
  assign acc       = s_axis_tvalid & s_axis_tready;
  assign b         = s_axis_tdata[BYTE_W-1:0];
  assign ok        = (err_q == ST_OK);
  assign is_nul    = (b == '0);
  assign code_slot = (rem_q == '0);
  assign want      = ok & ~is_nul & (code_slot ? zp_q : 1'b1);
  assign full      = (CMP_W'(cnt_q) >= CMP_W'(max_len_q)) | (&cnt_q);
  assign ovf       = want & full;
  assign emit      = want & ~full;
  assign adv       = ok & ~is_nul & ~ovf;

  always_comb begin
    err_step = err_q;
    if (ok && is_nul) begin
      err_step = ST_NUL;
    end else if (ok && ovf) begin
      err_step = ST_OVF;
    end
    cnt_step = emit ? cnt_q + LEN_BITS'(1) : cnt_q;
    rem_step = rem_q;
    zp_step  = zp_q;
    if (adv) begin
      if (code_slot) begin
        rem_step = b - 8'd1;
        zp_step  = (b != CODE_MAX);
      end else begin
        rem_step = rem_q - 8'd1;
      end
    end
    // block cut short by frame end
    err_fin = (err_step == ST_OK && rem_step != '0) ? ST_SHORT : err_step;
  end

  always_comb begin
    rem_d = rem_q;
    zp_d  = zp_q;
    cnt_d = cnt_q;
    err_d = err_q;
    if (acc) begin
      if (s_axis_tlast) begin
        rem_d = '0;
        zp_d  = 1'b0;
        cnt_d = '0;
        err_d = ST_OK;
      end else begin
        rem_d = rem_step;
        zp_d  = zp_step;
        cnt_d = cnt_step;
        err_d = err_step;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      zp_q  <= 1'b0;
      cnt_q <= '0;
      err_q <= ST_OK;
    end else begin
      rem_q <= rem_d;
      zp_q  <= zp_d;
      cnt_q <= cnt_d;
      err_q <= err_d;
    end
  end

  // Results
  assign push.data_v = acc & emit;
  assign push.stat_v = acc & s_axis_tlast;

  always_comb begin
    data_res                = '0;
    data_res.out_byte       = code_slot ? 8'd0 : b;
    stat_res                = '0;
    stat_res.frame_end      = 1'b1;
    stat_res.status         = err_fin;
    stat_res.decoded_length = LEN_W'(cnt_step);
  end

  cobs_dec_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .data_res_i  (data_res),
    .stat_res_i  (stat_res),
    .pop_i       (m_axis_tready),
    .head_o      (head),
    .not_empty_o (m_axis_tvalid),
    .room2_o     (room2)
  );

  assign s_axis_tready = room2;
  assign m_axis_tlast  = head.frame_end;
  assign m_axis_tdata  = {6'd0, head.decoded_length, head.status, head.out_byte};

  // Checks
  a_clear_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.stat_v |=> (cnt_q == '0 && rem_q == '0 && !zp_q && err_q == ST_OK))
    else $error("decoder state not cleared after frame end");

  a_no_emit_after_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && err_q != ST_OK) |-> !push.data_v)
    else $error("data item emitted after error");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push.data_v && !push.stat_v) |=> (cnt_q == $past(cnt_q) + LEN_BITS'(1)))
    else $error("decoded count did not advance with data item");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != ST_OK && !(acc && s_axis_tlast)) |=> (err_q == $past(err_q)))
    else $error("error code changed inside frame");

endmodule

// ----- dv/cobs_frame_decoder_unit_test.sv -----
// Self-checking testbench for the COBS frame decoder: framed byte stimulus and result scoreboard.
`timescale 1ns / 100ps

import cobs_dec_pkg::*;

class cobs_decode_board;
  res_t              due_results[$];
  logic [CFG_W-1:0]  capacity;
  logic [7:0]        blk_left;
  logic              zero_held;
  logic [LEN_W-1:0]  dec_count;
  logic [STAT_W-1:0] frame_err;
  int                errors;
  int                items_used;
  int                bytes_out;
  int                frames_by_status[4];

  function new();
    capacity   = MAX_OUT_LEN_RST;
    blk_left   = '0;
    zero_held  = 1'b0;
    dec_count  = '0;
    frame_err  = ST_OK;
    errors     = 0;
    items_used = 0;
    bytes_out  = 0;
    foreach (frames_by_status[i]) frames_by_status[i] = 0;
  endfunction

  // Queue one decoded byte, or flag overflow when the frame is full.
  function void emit_decoded(logic [7:0] v);
    res_t r;
    if (dec_count >= capacity || dec_count == {LEN_W{1'b1}}) begin
      frame_err = ST_OVF;
    end else begin
      r = '0;
      r.out_byte = v;
      due_results.push_back(r);
      dec_count = dec_count + 1'b1;
      bytes_out++;
    end
  endfunction

  function void take_encoded(logic [7:0] b, logic last);
    res_t r;
    items_used++;
    if (frame_err == ST_OK) begin
      if (b == 8'h00) begin
        frame_err = ST_NUL;
      end else if (blk_left == 8'h00) begin
        // code item: release the zero implied by the previous block
        if (zero_held) emit_decoded(8'h00);
        if (frame_err == ST_OK) begin
          blk_left  = b - 8'd1;
          zero_held = (b != CODE_MAX);
        end
      end else begin
        emit_decoded(b);
        if (frame_err == ST_OK) blk_left = blk_left - 8'd1;
      end
    end
    if (last) begin
      if (frame_err == ST_OK && blk_left != 8'h00) frame_err = ST_SHORT;
      r = '0;
      r.frame_end      = 1'b1;
      r.status         = frame_err;
      r.decoded_length = dec_count;
      due_results.push_back(r);
      frames_by_status[frame_err]++;
      blk_left  = '0;
      zero_held = 1'b0;
      dec_count = '0;
      frame_err = ST_OK;
    end
  endfunction

  function void match_result(logic [OUT_TDATA_W-1:0] tdata, logic tlast);
    res_t want;
    res_t got;
    got.out_byte       = tdata[7:0];
    got.status         = tdata[9:8];
    got.decoded_length = tdata[25:10];
    got.frame_end      = tlast;
    if (due_results.size() == 0) begin
      errors++;
      if (errors < 40)
        $display("%0t: unexpected result: expected none, got end=%b status=%0d len=%0d byte=%h",
                 $time, got.frame_end, got.status, got.decoded_length, got.out_byte);
      return;
    end
    want = due_results.pop_front();
    if (got !== want) begin
      errors++;
      if (errors < 40)
        $display("%0t: mismatch: expected end=%b st=%0d len=%0d byte=%h, got %b %0d %0d %h",
                 $time, want.frame_end, want.status, want.decoded_length, want.out_byte,
                 got.frame_end, got.status, got.decoded_length, got.out_byte);
    end
  endfunction
endclass

module cobs_frame_decoder_unit_test;
  localparam int HOLD_CYCLES  = 120;
  localparam int RUN_LIMIT_NS = 10_000_000;
  localparam logic [ADDR_W-1:0] ADDR_MAX_OUT_LEN = {REG_MAX_OUT_LEN, 2'b00};

  typedef enum int {FR_CLEAN, FR_NUL, FR_CUT, FR_NOISE} frame_kind_e;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;   // [7:0] byte_in
  logic                   s_axis_tlast;   // frame_last
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;   // [7:0] out_byte, [9:8] status, [25:10] decoded_length
  logic                   m_axis_tlast;   // frame_end
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [ADDR_W-1:0]      paddr;
  logic [31:0]            pwdata;
  logic [31:0]            prdata;
  logic                   pready;

  cobs_decode_board board = new();
  bit hold_req;

  cobs_frame_decoder_unit dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("cobs_frame_decoder_unit_test: FAIL");
    $finish;
  end

  // Output side: random stalls per item, runs without stalls, one long hold-off on request.
  initial begin
    int stall;
    int run_left;
    bit quiet_run;
    run_left  = 0;
    quiet_run = 1'b0;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      if (run_left == 0) begin
        run_left  = $urandom_range(20, 80);
        quiet_run = ($urandom_range(0, 3) == 0);
      end
      run_left--;
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_req = 1'b0;
      end else begin
        stall = quiet_run ? 0 : $urandom_range(0, 6);
        if (stall > 0) begin
          m_axis_tready <= 1'b0;
          repeat (stall) @(negedge clk_i);
        end
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      board.match_result(m_axis_tdata, m_axis_tlast);
      @(negedge clk_i);
    end
  end

  // Starts and ends at a falling edge; tvalid stays up for the next item.
  task automatic push_item(input logic [7:0] b, input logic last, input bit eager);
    int gap;
    gap = eager ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    board.take_encoded(b, last);
    @(negedge clk_i);
  endtask

  task automatic send_bytes(input logic [7:0] enc[$]);
    bit eager;
    eager = ($urandom_range(0, 3) == 0);
    foreach (enc[i]) push_item(enc[i], i == enc.size() - 1, eager);
  endtask

  task automatic send_random_frame();
    logic [7:0] enc[$];
    int pick;
    int code;
    int cut;
    frame_kind_e kind;
    pick = $urandom_range(0, 9);
    case (pick)
      7:       kind = FR_NUL;
      8:       kind = FR_CUT;
      9:       kind = FR_NOISE;
      default: kind = FR_CLEAN;
    endcase
    repeat ($urandom_range(1, 3)) begin
      pick = $urandom_range(0, 59);
      code = (pick == 0) ? 255 : (pick == 1) ? $urandom_range(13, 254) : $urandom_range(1, 8);
      enc.push_back(code[7:0]);
      repeat (code - 1) enc.push_back(8'($urandom_range(1, 255)));
    end
    case (kind)
      FR_NUL: enc[$urandom_range(0, enc.size() - 1)] = 8'h00;
      FR_CUT: begin
        cut = $urandom_range(1, enc.size());
        while (enc.size() > cut) void'(enc.pop_back());
      end
      FR_NOISE: begin
        enc.delete();
        repeat ($urandom_range(1, 8)) enc.push_back(8'($urandom_range(0, 255)));
      end
      default: ;
    endcase
    send_bytes(enc);
  endtask

  task automatic random_frames(input int quota);
    int stop_at;
    stop_at = board.items_used + quota;
    while (board.items_used < stop_at) send_random_frame();
  endtask

  // Drop tvalid and let every due result come out.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (board.due_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic program_capacity(input logic [CFG_W-1:0] val);
    wait_drained();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_MAX_OUT_LEN;
    pwdata  <= 32'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    board.capacity = val;
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(val)) begin
      board.errors++;
      $display("%0t: max_out_len readback: expected %h, got %h", $time, 32'(val), prdata);
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  initial begin
    logic [7:0] frame[$];
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    hold_req      = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // capacity at its reset value
    frame = '{8'h01};                             // empty frame
    send_bytes(frame);
    frame = '{8'h03, 8'h11, 8'h22, 8'h02, 8'h33}; // implied zero mid-frame, trailing one dropped
    send_bytes(frame);
    frame = '{8'h02, 8'hFF, 8'h01};               // 0xFF as data, lone zero released by code 1
    send_bytes(frame);
    frame = '{8'h00};                             // NUL as code
    send_bytes(frame);
    frame = '{8'h04, 8'h80, 8'h00, 8'h7F};        // NUL as data, rest dropped
    send_bytes(frame);
    frame = '{8'h05, 8'hAA};                      // block cut short by frame end
    send_bytes(frame);

    program_capacity(16'd1);
    frame = '{8'h03, 8'h11, 8'h22};               // second data byte overflows
    send_bytes(frame);
    frame = '{8'h02, 8'h11, 8'h01};               // released zero overflows
    send_bytes(frame);
    random_frames(200);

    program_capacity(16'd0);
    frame = '{8'h02, 8'h55};                      // no room at all
    send_bytes(frame);
    random_frames(100);

    program_capacity(16'($urandom_range(2, 40)));
    random_frames(500);

    program_capacity(16'($urandom_range(41, 65534)));
    random_frames(500);

    // hold the output long enough to back up into the input
    program_capacity(16'hFFFF);
    hold_req = 1'b1;
    random_frames(700);

    wait_drained();
    $display("Run covered %0d frames: %0d clean, %0d NUL, %0d short block, %0d overflow.",
             board.frames_by_status[ST_OK] + board.frames_by_status[ST_NUL] +
             board.frames_by_status[ST_SHORT] + board.frames_by_status[ST_OVF],
             board.frames_by_status[ST_OK], board.frames_by_status[ST_NUL],
             board.frames_by_status[ST_SHORT], board.frames_by_status[ST_OVF]);
    $display("%0d items in, %0d bytes out; capacities 65535, 1, 0, small, mid; %0d-cycle hold.",
             board.items_used, board.bytes_out, HOLD_CYCLES);
    if (board.errors == 0 && board.due_results.size() == 0) begin
      $display("cobs_frame_decoder_unit_test: PASS");
    end else begin
      $display("cobs_frame_decoder_unit_test: FAIL");
    end
    $finish;
  end
endmodule
